@@ sv/cabr_pkg.sv @@
// ----------------------------------------------------------------------------
// cabr_pkg
// shared widths, character codes, lexer modes and expansion tables for the
// comment-aware bracket rewriter
// ----------------------------------------------------------------------------
package cabr_pkg;

	localparam int BYTE_W = 8;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [1:0]        mode_t;
	typedef logic [1:0]        run_kind_t;
	typedef logic [2:0]        run_idx_t;

	// characters of interest
	localparam byte_t CH_OPEN   = 8'h5B;
	localparam byte_t CH_CLOSE  = 8'h5D;
	localparam byte_t CH_STAR   = 8'h2A;
	localparam byte_t CH_SLASH  = 8'h2F;
	localparam byte_t CH_QUOTE  = 8'h22;
	localparam byte_t CH_NL     = 8'h0A;
	localparam byte_t CH_BSLASH = 8'h5C;
	localparam byte_t CH_NUL    = 8'h00;

	// lexer modes
	localparam mode_t MODE_NORMAL = 2'd0;
	localparam mode_t MODE_BLOCK  = 2'd1;
	localparam mode_t MODE_LINE   = 2'd2;
	localparam mode_t MODE_STRING = 2'd3;

	// kinds of output run caused by one input byte
	localparam run_kind_t RUN_SINGLE = 2'd0;
	localparam run_kind_t RUN_OPEN   = 2'd1;
	localparam run_kind_t RUN_CLOSE  = 2'd2;

	// index of the final byte of each expansion
	localparam run_idx_t OPEN_LAST  = 3'd7;
	localparam run_idx_t CLOSE_LAST = 3'd6;

	// "[(int)(("
	function automatic byte_t open_char(input run_idx_t idx);
		byte_t c;
		case (idx)
			3'd0: c = 8'h5B;
			3'd1: c = 8'h28;
			3'd2: c = 8'h69;
			3'd3: c = 8'h6E;
			3'd4: c = 8'h74;
			3'd5: c = 8'h29;
			3'd6: c = 8'h28;
			3'd7: c = 8'h28;
			default: c = 8'h28;
		endcase
		return c;
	endfunction

	// ")+0.5)]"
	function automatic byte_t close_char(input run_idx_t idx);
		byte_t c;
		case (idx)
			3'd0: c = 8'h29;
			3'd1: c = 8'h2B;
			3'd2: c = 8'h30;
			3'd3: c = 8'h2E;
			3'd4: c = 8'h35;
			3'd5: c = 8'h29;
			3'd6: c = 8'h5D;
			default: c = 8'h5D;
		endcase
		return c;
	endfunction

	function automatic byte_t run_char(input run_kind_t kind, input run_idx_t idx);
		byte_t c;
		case (kind)
			RUN_OPEN:  c = open_char(idx);
			RUN_CLOSE: c = close_char(idx);
			default:   c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic logic run_is_last(input run_kind_t kind, input run_idx_t idx);
		logic l;
		case (kind)
			RUN_OPEN:  l = (idx == OPEN_LAST);
			RUN_CLOSE: l = (idx == CLOSE_LAST);
			default:   l = 1'b1;
		endcase
		return l;
	endfunction

endpackage

@@ sv/cabr_in_if.sv @@
// ----------------------------------------------------------------------------
// cabr_in_if
// source text channel: one byte per transfer
// ----------------------------------------------------------------------------
interface cabr_in_if;
	import cabr_pkg::*;

	logic  valid;
	logic  ready;
	byte_t in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

@@ sv/cabr_out_if.sv @@
// ----------------------------------------------------------------------------
// cabr_out_if
// rewritten text channel: one byte and an end-of-run flag per transfer
// ----------------------------------------------------------------------------
interface cabr_out_if;
	import cabr_pkg::*;

	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

@@ sv/comment_aware_bracket_rewriter_top.sv @@
// ----------------------------------------------------------------------------
// comment_aware_bracket_rewriter_top
// rewrites a byte stream of c-like source, expanding brackets found in code
// ----------------------------------------------------------------------------
// usage
//   source_text carries one source byte per transfer (valid/ready)
//   rewritten_text carries the rewritten bytes; last_of_run marks the final
//   byte produced by each source byte
//   a plain byte, or any byte inside a comment or string, gives one output
//   byte in the cycle after its transfer; while rewritten_text is ready,
//   the sustained rate is one byte per cycle; '[' in code gives 8 output
//   bytes and ']' gives 7, one per cycle while not stalled; the expansion
//   sequencer holds source_text off until the run's last byte is loaded
//   the output register accepts a new source byte in the same cycle its
//   current byte is transferred, so there are no bubbles while flowing
//   when rewritten_text stalls, the output byte holds and source_text
//   ready drops; nothing is lost or repeated
//   reset puts the lexer in normal code mode with a zero previous byte and
//   empties the output register
// ----------------------------------------------------------------------------
module comment_aware_bracket_rewriter_top (
	input logic        clk,
	input logic        arst_n,
	cabr_in_if.sink    source_text,
	cabr_out_if.source rewritten_text
);
	import cabr_pkg::*;

	// lexer state
	mode_t mode_q;
	byte_t prev_q;

	// output register
	logic  out_valid_q;
	byte_t out_byte_q;
	logic  out_last_q;

	// expansion sequencer
	logic      busy_q;
	run_kind_t kind_q;
	run_idx_t  idx_q;

	// next-state decode of the incoming byte
	byte_t     c;
	mode_t     mode_d;
	byte_t     prev_d;
	run_kind_t kind_d;
	byte_t     first_byte;

	logic out_free;
	logic take_in;
	logic run_done;

	assign c = source_text.in_byte;

	always_comb begin
		mode_d = mode_q;
		prev_d = c;
		kind_d = RUN_SINGLE;
		case (mode_q)
			MODE_BLOCK: begin
				if (prev_q == CH_STAR && c == CH_SLASH) mode_d = MODE_NORMAL;
			end
			MODE_LINE: begin
				// backslash-newline continues the line comment
				if (prev_q != CH_BSLASH && c == CH_NL) mode_d = MODE_NORMAL;
			end
			MODE_STRING: begin
				if (c == CH_QUOTE) mode_d = MODE_NORMAL;
			end
			default: begin
				if (prev_q == CH_SLASH && c == CH_STAR) begin
					mode_d = MODE_BLOCK;
					// forget the star so a following slash cannot close it
					prev_d = CH_NUL;
				end else if (prev_q == CH_SLASH && c == CH_SLASH) begin
					mode_d = MODE_LINE;
				end else if (c == CH_QUOTE) begin
					mode_d = MODE_STRING;
				end else if (c == CH_OPEN) begin
					kind_d = RUN_OPEN;
				end else if (c == CH_CLOSE) begin
					kind_d = RUN_CLOSE;
				end
			end
		endcase
	end

	// first output byte of the run: the byte itself or expansion entry zero
	assign first_byte = (kind_d == RUN_SINGLE) ? c : run_char(kind_d, '0);

	// output slot can be loaded when empty or being drained this cycle
	assign out_free = !out_valid_q || rewritten_text.ready;
	assign source_text.ready = !busy_q && out_free;
	assign take_in = source_text.valid && source_text.ready;
	assign run_done = run_is_last(kind_q, idx_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NORMAL;
			prev_q      <= CH_NUL;
			out_valid_q <= 1'b0;
			busy_q      <= 1'b0;
		end else begin
			if (take_in) begin
				mode_q <= mode_d;
				prev_q <= prev_d;
			end
			if (busy_q && out_free) begin
				out_valid_q <= 1'b1;
				if (run_done) busy_q <= 1'b0;
			end else if (take_in) begin
				out_valid_q <= 1'b1;
				busy_q      <= (kind_d != RUN_SINGLE);
			end else if (rewritten_text.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and expansion position
	always_ff @(posedge clk) begin
		if (busy_q && out_free) begin
			out_byte_q <= run_char(kind_q, idx_q);
			out_last_q <= run_done;
			idx_q      <= idx_q + 3'd1;
		end else if (take_in) begin
			out_byte_q <= first_byte;
			out_last_q <= (kind_d == RUN_SINGLE);
			kind_q     <= kind_d;
			idx_q      <= 3'd1;
		end
	end

	assign rewritten_text.valid       = out_valid_q;
	assign rewritten_text.out_byte    = out_byte_q;
	assign rewritten_text.last_of_run = out_last_q;

endmodule
